@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, held off during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hw/rtl/dtpc_pkg.sv @@
// Package for the disparity to point cloud block: word types, register codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dtpc_pkg;
    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_W = 18;
    localparam int NUM_W = 36;
    localparam int FOC_W = 16;

    localparam logic [2:0] CFG_FOCAL_BASELINE = 3'd0;
    localparam logic [2:0] CFG_FOCAL_X        = 3'd1;
    localparam logic [2:0] CFG_FOCAL_Y        = 3'd2;
    localparam logic [2:0] CFG_CENTER_X       = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y       = 3'd4;
    localparam logic [2:0] CFG_MAX_DEPTH      = 3'd5;
    localparam logic [2:0] CFG_CAL_READY      = 3'd6;

    typedef struct packed {
        logic signed [15:0] disparity_raw;
        logic [11:0]        column;
        logic [11:0]        row;
    } t_in_word;

    typedef struct packed {
        logic [17:0]        depth;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               point_valid;
    } t_out_word;
endpackage
`default_nettype wire

@@ hw/rtl/disparity_to_point_cloud_top.sv @@
// Top level: stereo disparity to depth and back-projected X/Y point.
// Depends on dtpc_pkg and assert_macros.svh.
//
//  channel | direction | signals
//  in      | in        | i_in_valid, o_in_ready, i_in_word
//  out     | out       | o_out_valid, i_out_ready, o_out_word
//  cfg     | in        | i_cfg_we, i_cfg_idx, i_cfg_data
//
// One word per cycle while the output register is empty or being taken; the depth
// divider and the coordinate dividers each resolve one quotient bit per stage.
// Synchronous active-low reset clears valid bits and sets configuration registers to defaults.
// The whole pipeline holds while a result waits on the output register.
// Words arriving while calibration is not ready are dropped at entry.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module disparity_to_point_cloud_top
    import dtpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_word        o_out_word,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    localparam int CW = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
    localparam int PW = CW + DEPTH_W;
    localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);

    logic [31:0] r_fb;
    logic [15:0] r_fx, r_fy, r_cx, r_cy;
    logic [17:0] r_maxd;
    logic        r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb <= '0; r_fx <= 16'd16; r_fy <= 16'd16;
            r_cx <= '0; r_cy <= '0; r_maxd <= 18'd160000; r_cal <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOCAL_BASELINE: r_fb   <= i_cfg_data;
                CFG_FOCAL_X:        r_fx   <= i_cfg_data[15:0];
                CFG_FOCAL_Y:        r_fy   <= i_cfg_data[15:0];
                CFG_CENTER_X:       r_cx   <= i_cfg_data[15:0];
                CFG_CENTER_Y:       r_cy   <= i_cfg_data[15:0];
                CFG_MAX_DEPTH:      r_maxd <= i_cfg_data[17:0];
                CFG_CAL_READY:      r_cal  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // entry stage
    logic [11:0] colm, rowm;
    logic [CW:0] px, py, cxw, cyw, dxw, dyw;
    logic        nx, ny;
    assign colm = i_in_word.column & CMASK;
    assign rowm = i_in_word.row & CMASK;
    assign px  = (CW+1)'({colm, 4'b0});
    assign py  = (CW+1)'({rowm, 4'b0});
    assign cxw = (CW+1)'(r_cx);
    assign cyw = (CW+1)'(r_cy);
    assign nx  = px < cxw;
    assign ny  = py < cyw;
    assign dxw = nx ? cxw - px : px - cxw;
    assign dyw = ny ? cyw - py : py - cyw;

    // depth divider: stage k holds numerator shift, remainder, quotient
    logic            r_av [0:NUM_W];
    logic [NUM_W-1:0] r_an [0:NUM_W];
    logic [NUM_W-1:0] r_aq [0:NUM_W];
    logic [14:0]     r_ar [0:NUM_W];
    logic [14:0]     r_ad [0:NUM_W];
    logic            r_aok[0:NUM_W];
    logic [CW-1:0]   r_adx[0:NUM_W];
    logic [CW-1:0]   r_ady[0:NUM_W];
    logic            r_anx[0:NUM_W];
    logic            r_any[0:NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av[0] <= 1'b0;
        else if (adv) r_av[0] <= i_in_valid && r_cal;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_an[0]  <= {r_fb, 4'b0};
            r_aq[0]  <= '0;
            r_ar[0]  <= '0;
            r_ad[0]  <= i_in_word.disparity_raw[14:0];
            r_aok[0] <= !i_in_word.disparity_raw[15] && (i_in_word.disparity_raw[14:0] >= 15'd2);
            r_adx[0] <= dxw[CW-1:0];
            r_ady[0] <= dyw[CW-1:0];
            r_anx[0] <= nx;
            r_any[0] <= ny;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_ddiv
        logic [15:0] trial;
        logic        ge;
        logic [15:0] sub;
        assign trial = {r_ar[k], r_an[k][NUM_W-1]};
        assign ge    = trial >= {1'b0, r_ad[k]};
        assign sub   = trial - {1'b0, r_ad[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_av[k+1] <= 1'b0;
            else if (adv) r_av[k+1] <= r_av[k];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_an[k+1]  <= {r_an[k][NUM_W-2:0], 1'b0};
                r_aq[k+1]  <= {r_aq[k][NUM_W-2:0], ge};
                r_ar[k+1]  <= ge ? sub[14:0] : trial[14:0];
                r_ad[k+1]  <= r_ad[k];
                r_aok[k+1] <= r_aok[k];
                r_adx[k+1] <= r_adx[k];
                r_ady[k+1] <= r_ady[k];
                r_anx[k+1] <= r_anx[k];
                r_any[k+1] <= r_any[k];
            end
        end
    end

    // range check
    logic          r_cv, r_cok;
    logic [17:0]   r_cdep;
    logic [CW-1:0] r_cdx, r_cdy;
    logic          r_cnx, r_cny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (adv) r_cv <= r_av[NUM_W];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cok  <= r_aok[NUM_W] && (r_aq[NUM_W] != '0)
                      && (r_aq[NUM_W] < NUM_W'(r_maxd));
            r_cdep <= r_aq[NUM_W][17:0];
            r_cdx  <= r_adx[NUM_W];
            r_cdy  <= r_ady[NUM_W];
            r_cnx  <= r_anx[NUM_W];
            r_cny  <= r_any[NUM_W];
        end
    end

    // products
    logic          r_mv, r_mok, r_mnx, r_mny, r_mzx, r_mzy;
    logic [17:0]   r_mdep;
    logic [PW-1:0] r_mpx, r_mpy;
    logic [PW-1:0] prx, pry;
    assign prx = PW'(r_cdx) * PW'(r_cdep);
    assign pry = PW'(r_cdy) * PW'(r_cdep);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (adv) r_mv <= r_cv;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mok  <= r_cok;
            r_mdep <= r_cok ? r_cdep : '0;
            r_mpx  <= prx;
            r_mpy  <= pry;
            r_mzx  <= prx == '0;
            r_mzy  <= pry == '0;
            r_mnx  <= r_cnx;
            r_mny  <= r_cny;
        end
    end

    // coordinate dividers, one bit per stage, divisors from configuration
    logic          r_bv  [0:PW];
    logic          r_bok [0:PW];
    logic [17:0]   r_bdep[0:PW];
    logic [PW-1:0] r_bnx_n[0:PW], r_bny_n[0:PW];
    logic [PW-1:0] r_bqx[0:PW], r_bqy[0:PW];
    logic [15:0]   r_brx[0:PW], r_bry[0:PW];
    logic          r_bnx[0:PW], r_bny[0:PW], r_bzx[0:PW], r_bzy[0:PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv[0] <= 1'b0;
        else if (adv) r_bv[0] <= r_mv;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bok[0] <= r_mok; r_bdep[0] <= r_mdep;
            r_bnx_n[0] <= r_mpx; r_bny_n[0] <= r_mpy;
            r_bqx[0] <= '0; r_bqy[0] <= '0; r_brx[0] <= '0; r_bry[0] <= '0;
            r_bnx[0] <= r_mnx; r_bny[0] <= r_mny; r_bzx[0] <= r_mzx; r_bzy[0] <= r_mzy;
        end
    end

    for (genvar k = 0; k < PW; k++) begin : g_cdiv
        logic [16:0] tx, ty, sx, sy;
        logic        gx, gy;
        assign tx = {r_brx[k], r_bnx_n[k][PW-1]};
        assign ty = {r_bry[k], r_bny_n[k][PW-1]};
        assign gx = tx >= {1'b0, r_fx};
        assign gy = ty >= {1'b0, r_fy};
        assign sx = tx - {1'b0, r_fx};
        assign sy = ty - {1'b0, r_fy};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_bv[k+1] <= 1'b0;
            else if (adv) r_bv[k+1] <= r_bv[k];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_bok[k+1]   <= r_bok[k];
                r_bdep[k+1]  <= r_bdep[k];
                r_bnx_n[k+1] <= {r_bnx_n[k][PW-2:0], 1'b0};
                r_bny_n[k+1] <= {r_bny_n[k][PW-2:0], 1'b0};
                r_bqx[k+1]   <= {r_bqx[k][PW-2:0], gx};
                r_bqy[k+1]   <= {r_bqy[k][PW-2:0], gy};
                r_brx[k+1]   <= gx ? sx[15:0] : tx[15:0];
                r_bry[k+1]   <= gy ? sy[15:0] : ty[15:0];
                r_bnx[k+1]   <= r_bnx[k];
                r_bny[k+1]   <= r_bny[k];
                r_bzx[k+1]   <= r_bzx[k];
                r_bzy[k+1]   <= r_bzy[k];
            end
        end
    end

    // saturate and drive the output register
    localparam logic [PW:0] MAXP = (PW+1)'(33'h07FFFFFFF);
    localparam logic [PW:0] MAXN = (PW+1)'(33'h080000000);
    logic [PW:0]  mx, my, cmx, cmy;
    logic [31:0]  ox, oy;
    assign mx  = (r_fx == '0) ? (r_bnx[PW] ? MAXN : MAXP) : (PW+1)'(r_bqx[PW]);
    assign my  = (r_fy == '0) ? (r_bny[PW] ? MAXN : MAXP) : (PW+1)'(r_bqy[PW]);
    assign cmx = r_bnx[PW] ? ((mx > MAXN) ? MAXN : mx) : ((mx > MAXP) ? MAXP : mx);
    assign cmy = r_bny[PW] ? ((my > MAXN) ? MAXN : my) : ((my > MAXP) ? MAXP : my);
    assign ox  = (!r_bok[PW] || r_bzx[PW]) ? 32'd0
                 : (r_bnx[PW] ? 32'd0 - cmx[31:0] : cmx[31:0]);
    assign oy  = (!r_bok[PW] || r_bzy[PW]) ? 32'd0
                 : (r_bny[PW] ? 32'd0 - cmy[31:0] : cmy[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out_valid <= 1'b0;
        else if (adv) o_out_valid <= r_bv[PW];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_word.depth       <= r_bdep[PW];
            o_out_word.point_x     <= ox;
            o_out_word.point_y     <= oy;
            o_out_word.point_valid <= r_bok[PW];
        end
    end

    `ASSERT_CLK(a_valid_range, i_clk, i_rst_n,
        o_out_valid && o_out_word.point_valid |-> o_out_word.depth != '0,
        "valid point with zero depth")
    `ASSERT_CLK(a_invalid_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_word.point_valid |-> o_out_word.depth == '0
        && o_out_word.point_x == '0 && o_out_word.point_y == '0,
        "invalid point with non-zero fields")
    `ASSERT_CLK(a_entry_gate, i_clk, i_rst_n,
        i_in_valid && o_in_ready && !r_cal |=> !r_av[0],
        "word entered while calibration not ready")
endmodule
`default_nettype wire

@@ tb/sv/tb_disparity_to_point_cloud_top.sv @@
// Self-checking bench for disparity_to_point_cloud_top: directed and random disparity words
// under bursty input and output stalls, checked against a built-in point predictor.
// Depends on dtpc_pkg and the top-level RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_disparity_to_point_cloud_top;
    import dtpc_pkg::*;

    localparam int LATENCY   = 80;
    localparam int WDOG_MAX  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    disparity_to_point_cloud_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [31:0] fb_q;
    logic [15:0] fx_q, fy_q, cx_q, cy_q;
    logic [17:0] maxd_q;
    logic        cal_q;

    t_in_word  pending_words[$];
    t_out_word points_due[$];
    int        mismatches = 0;
    bit        timed_out = 1'b0;
    bit        feed_hold = 1'b0;
    int        hold_off = 0;
    int        idle_cycles = 0;

    function automatic logic [31:0] project(logic [11:0] pix, logic [15:0] ctr,
                                            logic [17:0] dep, logic [15:0] foc);
        logic [63:0] p16, diff, num, mag;
        bit neg;
        p16 = 64'(pix) * 16;
        neg = p16 < 64'(ctr);
        diff = neg ? 64'(ctr) - p16 : p16 - 64'(ctr);
        num = diff * 64'(dep);
        if (num == 0) return '0;
        if (foc == 0) mag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        else mag = num / 64'(foc);
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic void predict_point(t_in_word w);
        t_out_word r;
        logic [63:0] q;
        logic [15:0] raw;
        r = '0;
        raw = w.disparity_raw;
        if (!cal_q) return;
        if (!raw[15] && raw >= 2) begin
            q = (64'(fb_q) * 16) / 64'(raw);
            if (q != 0 && q < 64'(maxd_q)) begin
                r.depth = q[17:0];
                r.point_x = project(w.column, cx_q, q[17:0], fx_q);
                r.point_y = project(w.row, cy_q, q[17:0], fy_q);
                r.point_valid = 1'b1;
            end
        end
        points_due.push_back(r);
    endfunction

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            predict_point(i_in_word);
        end
        if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !feed_hold && i_rst_n) begin
                i_in_valid <= 1'b1;
                i_in_word <= pending_words.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= int'($urandom_range(1, 40));
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (points_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_out_word);
            end else begin
                t_out_word e;
                e = points_due.pop_front();
                if (e.depth !== o_out_word.depth || e.point_x !== o_out_word.point_x ||
                    e.point_y !== o_out_word.point_y ||
                    e.point_valid !== o_out_word.point_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected d=%0d x=%0d y=%0d v=%b, got d=%0d x=%0d y=%0d v=%b",
                            e.depth, e.point_x, e.point_y, e.point_valid,
                            o_out_word.depth, o_out_word.point_x,
                            o_out_word.point_y, o_out_word.point_valid);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FOCAL_BASELINE: fb_q = val;
            CFG_FOCAL_X:        fx_q = val[15:0];
            CFG_FOCAL_Y:        fy_q = val[15:0];
            CFG_CENTER_X:       cx_q = val[15:0];
            CFG_CENTER_Y:       cy_q = val[15:0];
            CFG_MAX_DEPTH:      maxd_q = val[17:0];
            CFG_CAL_READY:      cal_q = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_in_valid || points_due.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic push_word(logic [15:0] d, logic [11:0] c, logic [11:0] r);
        t_in_word w;
        w.disparity_raw = d;
        w.column = c;
        w.row = r;
        pending_words.push_back(w);
    endtask

    task automatic push_random(int n);
        logic [15:0] d;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: d = 16'($urandom);
                1: d = 16'($urandom_range(0, 3));
                2: d = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
                default: d = 16'($urandom_range(2, 2000));
            endcase
            push_word(d, 12'($urandom), 12'($urandom));
        end
    endtask

    task automatic set_cal(logic [31:0] fb, logic [15:0] fx, logic [15:0] fy,
                           logic [15:0] cx, logic [15:0] cy, logic [17:0] md);
        write_reg(CFG_FOCAL_BASELINE, fb);
        write_reg(CFG_FOCAL_X, 32'(fx));
        write_reg(CFG_FOCAL_Y, 32'(fy));
        write_reg(CFG_CENTER_X, 32'(cx));
        write_reg(CFG_CENTER_Y, 32'(cy));
        write_reg(CFG_MAX_DEPTH, 32'(md));
    endtask

    initial begin
        fb_q = 0; fx_q = 16; fy_q = 16; cx_q = 0; cy_q = 0; maxd_q = 160000; cal_q = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uncalibrated: words dropped
        feed_hold = 1'b1;
        push_word(16'd100, 12'd5, 12'd5);
        push_word(16'd2, 12'd0, 12'd0);
        feed_hold = 1'b0;
        drain();

        write_reg(CFG_CAL_READY, 32'd1);
        set_cal(32'd500000, 16'd8000, 16'd8000, 16'd5120, 16'd3840, 18'd160000);
        push_word(16'sh7FFF, 12'd0, 12'd0);
        push_word(16'sh8000, 12'd4095, 12'd4095);
        push_word(16'd1, 12'd10, 12'd10);
        push_word(16'd0, 12'd10, 12'd10);
        push_word(16'hFFFF, 12'd10, 12'd10);
        push_word(16'd2, 12'd320, 12'd240);
        push_word(16'd50, 12'd320, 12'd240);
        push_word(16'd50, 12'd0, 12'd4095);
        push_word(16'd50, 12'd4095, 12'd0);
        push_word(16'd800, 12'd1234, 12'd2345);
        drain();

        // zero focal lengths, extreme baseline and centre
        set_cal(32'hFFFF_FFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 18'h3FFFF);
        push_word(16'sh7FFF, 12'd0, 12'd0);
        push_word(16'sh7FFF, 12'd4095, 12'd4095);
        push_word(16'sh7000, 12'd4095, 12'd0);
        push_word(16'sh7FF0, 12'd100, 12'd100);
        drain();
        set_cal(32'd0, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 18'd1);
        push_word(16'd2, 12'd7, 12'd7);
        push_word(16'd100, 12'd4095, 12'd4095);
        drain();

        // long output hold-off while input keeps coming
        set_cal(32'd200000, 16'd9000, 16'd9000, 16'd20000, 16'd15000, 18'd200000);
        push_random(200);
        hold_off = 400;
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_cal(32'($urandom_range(1000, 3000000)), 16'($urandom_range(1, 65535)),
                    16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                    18'($urandom_range(1, 262143)));
            push_random(200);
            drain();
        end

        // calibration off after the random phases
        write_reg(CFG_CAL_READY, 32'd0);
        push_random(10);
        drain();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
